>>> sv/assert_macros.svh
// ------------------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the radix parser checkers.
// ------------------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> sv/crip_pkg.sv
// ------------------------------------------------------------------------------------------
// Radix parser package
// Types, constants and helper functions shared by the radix integer parser modules.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crip_pkg;

    // Sizes of the alphabet, the symbols and the result.
    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_W       = 8;
    localparam int IDX_W       = $clog2(MAX_SYMBOLS);
    localparam int RADIX_W     = 5;
    localparam int VALUE_WIDTH = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int SYMS_W      = MAX_SYMBOLS * SYM_W;

    // Special characters.
    localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CH_LF    = 8'h0A;
    localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
    localparam logic [SYM_W-1:0] CH_FF    = 8'h0C;
    localparam logic [SYM_W-1:0] CH_VT    = 8'h0B;
    localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOLS_LOW  = 2'd0,
        CFG_SYMBOLS_HIGH = 2'd1,
        CFG_RADIX_LENGTH = 2'd2
    } t_cfg_index;

    // One input item: a character and the end-of-string flag.
    typedef struct packed {
        logic [SYM_W-1:0] char_in;
        logic             last_char;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          alphabet_invalid;
    } t_out_item;

    // Result of the digit lookup for one character.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] index;
    } t_digit_match;

    // True for the six whitespace characters.
    function automatic logic is_space(input logic [SYM_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) ||
               (c == CH_FF) || (c == CH_VT) || (c == CH_CR);
    endfunction

    // True for a sign character.
    function automatic logic is_sign(input logic [SYM_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

`default_nettype wire

>>> sv/custom_radix_integer_parser_top.sv
// ------------------------------------------------------------------------------------------
// Radix integer parser
// Parses a signed integer from a character stream under a configurable digit alphabet.
// ------------------------------------------------------------------------------------------
// Usage:
//   Characters enter on the input channel (i_in_valid / o_in_ready / i_in), one per item,
//   with last_char set on the final character of a string. Leading whitespace is skipped,
//   a run of '+' and '-' sets the sign, then digits accumulate as acc * radix + index.
//   One result item leaves on the output channel (o_out_valid / i_out_ready / o_out) for
//   each string, on its last character; other characters give no result.
//   The alphabet is written through i_cfg_we / i_cfg_index / i_cfg_data while the block
//   is idle; an invalid alphabet gives value 0 with alphabet_invalid set.
//   A last character passes through the input register, then its result is loaded into the result register.
//   Throughput: one character per cycle while no last character waits on a held result,
//   set by one input register and one multiply-add stage before the result register.
//   Reset clears the alphabet registers, the parse state and both valid flags.
//   When the receiver stalls, the result register holds; further characters that give no
//   result keep flowing, and a second last character waits in the input register, which
//   drops o_in_ready until the held result is taken.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module custom_radix_integer_parser_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [crip_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [crip_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire crip_pkg::t_in_item             i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output crip_pkg::t_out_item                 o_out
);

    logic [crip_pkg::CFG_W-1:0]   r_symbols_low;
    logic [crip_pkg::CFG_W-1:0]   r_symbols_high;
    logic [crip_pkg::RADIX_W-1:0] r_radix;
    logic                         r_in_valid;
    crip_pkg::t_in_item           r_in;
    logic                         r_out_valid;
    crip_pkg::t_out_item          r_out;
    logic                         w_step;
    logic                         w_load_out;
    logic                         w_invalid;
    crip_pkg::t_digit_match       w_match;
    crip_pkg::t_out_item          w_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbols_low  <= '0;
            r_symbols_high <= '0;
            r_radix        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crip_pkg::CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_data;
                crip_pkg::CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_data;
                crip_pkg::CFG_RADIX_LENGTH: r_radix <= i_cfg_data[crip_pkg::RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    // The held item moves on unless it is a last character facing a full result register.
    assign w_step      = r_in_valid && (!r_in.last_char || !r_out_valid || i_out_ready);
    assign w_load_out  = w_step && r_in.last_char;
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    crip_alphabet u_alphabet (
        .i_symbols (crip_pkg::SYMS_W'({r_symbols_high, r_symbols_low})),
        .i_radix   (r_radix),
        .i_char    (r_in.char_in),
        .o_match   (w_match),
        .o_invalid (w_invalid)
    );

    crip_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_item    (r_in),
        .i_match   (w_match),
        .i_radix   (r_radix),
        .i_invalid (w_invalid),
        .o_result  (w_result)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_result;
        end
    end

endmodule

`default_nettype wire

>>> sv/crip_alphabet.sv
// ------------------------------------------------------------------------------------------
// Radix parser alphabet unit
// Looks up the digit index of a character and checks the configured alphabet.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crip_alphabet (
    input  wire logic [crip_pkg::SYMS_W-1:0]  i_symbols,
    input  wire logic [crip_pkg::RADIX_W-1:0] i_radix,
    input  wire logic [crip_pkg::SYM_W-1:0]   i_char,
    output crip_pkg::t_digit_match            o_match,
    output logic                              o_invalid
);

    logic [crip_pkg::SYM_W-1:0] w_sym [crip_pkg::MAX_SYMBOLS];

    // Split the symbol word into its byte symbols.
    always_comb begin
        for (int k = 0; k < crip_pkg::MAX_SYMBOLS; k++) begin
            w_sym[k] = i_symbols[k*crip_pkg::SYM_W +: crip_pkg::SYM_W];
        end
    end

    // Digit lookup: the lowest symbol in use that equals the character wins.
    always_comb begin
        o_match.hit   = 1'b0;
        o_match.index = '0;
        for (int k = crip_pkg::MAX_SYMBOLS - 1; k >= 0; k--) begin
            if ((crip_pkg::RADIX_W'(k) < i_radix) && (w_sym[k] == i_char)) begin
                o_match.hit   = 1'b1;
                o_match.index = crip_pkg::IDX_W'(k);
            end
        end
    end

    // Alphabet check: radix in range, no reserved byte, no repeated symbol.
    always_comb begin
        o_invalid = (i_radix < crip_pkg::RADIX_W'(2)) ||
                    (i_radix > crip_pkg::RADIX_W'(crip_pkg::MAX_SYMBOLS));
        for (int i = 0; i < crip_pkg::MAX_SYMBOLS; i++) begin
            if (crip_pkg::RADIX_W'(i) < i_radix) begin
                if ((w_sym[i] == crip_pkg::CH_NUL) || crip_pkg::is_space(w_sym[i]) ||
                    crip_pkg::is_sign(w_sym[i])) begin
                    o_invalid = 1'b1;
                end
                for (int j = i + 1; j < crip_pkg::MAX_SYMBOLS; j++) begin
                    if ((crip_pkg::RADIX_W'(j) < i_radix) && (w_sym[j] == w_sym[i])) begin
                        o_invalid = 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/crip_parse.sv
// ------------------------------------------------------------------------------------------
// Radix parser state unit
// Holds the parse phase, sign and accumulator and forms the result of a string.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crip_parse (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire crip_pkg::t_in_item           i_item,
    input  wire crip_pkg::t_digit_match       i_match,
    input  wire logic [crip_pkg::RADIX_W-1:0] i_radix,
    input  wire logic                         i_invalid,
    output crip_pkg::t_out_item               o_result
);

    typedef enum logic [3:0] {
        PH_SPACE = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    t_phase                           r_phase;
    t_phase                           n_phase;
    logic                             r_negative;
    logic                             n_negative;
    logic [crip_pkg::VALUE_WIDTH-1:0] r_acc;
    logic [crip_pkg::VALUE_WIDTH-1:0] n_acc;
    logic [crip_pkg::VALUE_WIDTH-1:0] w_signed;

    // Next parse state for the character in hand.
    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_acc      = r_acc;
        if ((r_phase == PH_SPACE) && crip_pkg::is_space(i_item.char_in)) begin
            n_phase = PH_SPACE;
        end else if (((r_phase == PH_SPACE) || (r_phase == PH_SIGN)) &&
                     crip_pkg::is_sign(i_item.char_in)) begin
            n_phase = PH_SIGN;
            if (i_item.char_in == crip_pkg::CH_MINUS) begin
                n_negative = ~r_negative;
            end
        end else if (r_phase != PH_DONE) begin
            if (i_match.hit) begin
                n_phase = PH_DIGIT;
                n_acc   = r_acc * crip_pkg::VALUE_WIDTH'(i_radix) +
                          crip_pkg::VALUE_WIDTH'(i_match.index);
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    // Result of the string, valid on its last character.
    always_comb begin
        w_signed                  = n_negative ? (~n_acc + 1'b1) : n_acc;
        o_result.alphabet_invalid = i_invalid;
        o_result.value            = i_invalid ? '0 : $signed(w_signed);
    end

    // State update; the last character returns the parser to its start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SPACE;
            r_negative <= 1'b0;
            r_acc      <= '0;
        end else if (i_step) begin
            if (i_item.last_char) begin
                r_phase    <= PH_SPACE;
                r_negative <= 1'b0;
                r_acc      <= '0;
            end else begin
                r_phase    <= n_phase;
                r_negative <= n_negative;
                r_acc      <= n_acc;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/crip_checker.sv
// ------------------------------------------------------------------------------------------
// Radix parser checker
// Port-level assertions on the radix parser, attached to the top level by bind.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crip_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire crip_pkg::t_in_item  i_in,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire crip_pkg::t_out_item o_out
);

    // A stalled result item stays shown and unchanged.
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out), "result item changed while stalled")

    // Reset leaves the block empty and ready for an item.
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> o_in_ready && !o_out_valid, "block not empty after reset")

    // The input side only stalls behind a result that the receiver holds back.
    `ASSERT_CLK(a_ready_cause, !o_in_ready |-> o_out_valid && !i_out_ready, "input stalled without a held result")

    // An invalid alphabet always reports a zero value.
    `ASSERT_CLK(a_invalid_zero, o_out_valid && o_out.alphabet_invalid |-> o_out.value == '0, "nonzero value with invalid alphabet")

endmodule

bind custom_radix_integer_parser_top crip_checker u_crip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
